### rtl/core/bti_pkg.sv
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int MaxRows  = 64;
    localparam int MaxCols  = 64;
    localparam int FracBits = 16;
    localparam int RowW     = $clog2(MaxRows);
    localparam int ColW     = $clog2(MaxCols);
    localparam int BankDepth = (MaxRows / 2) * (MaxCols / 2);
    localparam int BankAw    = $clog2(BankDepth);

    // Register stages from the accepting edge to the result register.
    localparam int Stages = 5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_X_START = 3'd0;
    localparam logic [2:0] CFG_X_END   = 3'd1;
    localparam logic [2:0] CFG_Y_START = 3'd2;
    localparam logic [2:0] CFG_Y_END   = 3'd3;
    localparam logic [2:0] CFG_X_SCALE = 3'd4;
    localparam logic [2:0] CFG_Y_SCALE = 3'd5;
    localparam logic [2:0] CFG_X_INTV  = 3'd6;
    localparam logic [2:0] CFG_Y_INTV  = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_INTERP  = 2'd0;
    localparam logic [1:0] ST_CLAMPED = 2'd1;
    localparam logic [1:0] ST_WR_DONE = 2'd2;
    localparam logic [1:0] ST_WR_OOR  = 2'd3;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] z_value;
        logic [1:0]         status;
    } t_out_item;

    // One item's position in one axis: base index and fraction (fraction
    // of exactly one is carried by the extra top bit).
    typedef struct packed {
        logic [RowW-1:0]   idx;
        logic [FracBits:0] frac;
    } t_axis_pos;

endpackage

### rtl/core/bilinear_table_interpolator.sv
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// o_valid follows the edge that accepts start through the valid pipe, for
// lookups and writes alike. Throughput: one item every cycle; busy is low.
// The grid lives in four banks by row and column parity, so the four
// neighbors are read together. Reset restores register defaults and
// clears the valid pipeline; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bti_pkg::t_in_item     i_item,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    output bti_pkg::t_out_item    o_item
);
    import bti_pkg::*;

    // Configuration registers.
    logic signed [31:0] r_x_start, r_x_end, r_y_start, r_y_end;
    logic [31:0] r_x_scale, r_y_scale;
    logic [5:0]  r_x_intv, r_y_intv;
    logic [5:0]  w_xi, w_yi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start <= '0;
            r_x_end   <= 32'sd65536;
            r_y_start <= '0;
            r_y_end   <= 32'sd65536;
            r_x_scale <= 32'd65536;
            r_y_scale <= 32'd65536;
            r_x_intv  <= 6'd1;
            r_y_intv  <= 6'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_START: r_x_start <= i_cfg_data;
                CFG_X_END:   r_x_end   <= i_cfg_data;
                CFG_Y_START: r_y_start <= i_cfg_data;
                CFG_Y_END:   r_y_end   <= i_cfg_data;
                CFG_X_SCALE: r_x_scale <= i_cfg_data;
                CFG_Y_SCALE: r_y_scale <= i_cfg_data;
                CFG_X_INTV:  r_x_intv  <= i_cfg_data[5:0];
                CFG_Y_INTV:  r_y_intv  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Zero intervals act as one.
    assign w_xi = (r_x_intv == 6'd0) ? 6'd1 : r_x_intv;
    assign w_yi = (r_y_intv == 6'd0) ? 6'd1 : r_y_intv;

    assign busy = 1'b0;

    // Valid and control travel along with the data.
    logic [Stages-1:0] r_vld;
    logic [Stages-2:0] r_wr;
    logic              n_vld0;

    assign n_vld0 = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Stages-2:0], n_vld0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr <= {r_wr[Stages-3:0], i_item.kind};
    end

    // Stage 1 register: write status, then carried down the pipe.
    logic [1:0] r_wst [Stages-1];
    logic       n_wok;
    assign n_wok = (i_item.row_index <= w_xi) && (i_item.col_index <= w_yi);

    always_ff @(posedge i_clk) begin
        r_wst[0] <= n_wok ? ST_WR_DONE : ST_WR_OOR;
        for (int s = 1; s < Stages - 1; s++) begin
            r_wst[s] <= r_wst[s-1];
        end
    end

    // Stages 1-2: axis position.
    logic      w_xout, w_yout;
    t_axis_pos w_xp, w_yp;
    logic [5:0] w_xc, w_yc;

    bti_axis u_xaxis (
        .i_clk(i_clk), .i_coord(i_item.x_coord), .i_start(r_x_start),
        .i_end(r_x_end), .i_scale(r_x_scale), .i_intv(w_xi),
        .o_outside(w_xout), .o_pos_interp(w_xp), .o_idx_clamp(w_xc)
    );

    bti_axis u_yaxis (
        .i_clk(i_clk), .i_coord(i_item.y_coord), .i_start(r_y_start),
        .i_end(r_y_end), .i_scale(r_y_scale), .i_intv(w_yi),
        .o_outside(w_yout), .o_pos_interp(w_yp), .o_idx_clamp(w_yc)
    );

    // Select the base cell; a clamped lookup reads its entry as z00.
    logic       w_out;
    logic [5:0] w_r0, w_c0, w_r1, w_c1;
    assign w_out = w_xout || w_yout;
    assign w_r0  = w_out ? w_xc : w_xp.idx;
    assign w_c0  = w_out ? w_yc : w_yp.idx;
    assign w_r1  = w_r0 + 6'd1;
    assign w_c1  = w_c0 + 6'd1;

    // Bank addressing: bank by parity, address by halved indexes.
    logic [5:0] w_rr [2];
    logic [5:0] w_cc [2];
    always_comb begin
        w_rr[0] = w_r0[0] ? w_r1 : w_r0;
        w_rr[1] = w_r0[0] ? w_r0 : w_r1;
        w_cc[0] = w_c0[0] ? w_c1 : w_c0;
        w_cc[1] = w_c0[0] ? w_c0 : w_c1;
    end

    logic [31:0] w_rd [4];
    logic        w_bwe [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        assign w_bwe[b] = n_vld0 && i_item.kind && n_wok
                          && (i_item.row_index[0] == 1'(b >> 1))
                          && (i_item.col_index[0] == 1'(b & 1));
        bti_ram #(.Width(32), .Depth(BankDepth)) u_ram (
            .i_clk(i_clk),
            .i_we(w_bwe[b]),
            .i_waddr({i_item.row_index[5:1], i_item.col_index[5:1]}),
            .i_wdata(i_item.entry_value),
            .i_raddr({w_rr[1'(b >> 1)][5:1], w_cc[1'(b & 1)][5:1]}),
            .o_rdata(w_rd[b])
        );
    end

    // Stage 2 register: parities and fractions alongside the read.
    logic                r_pr, r_pc, r_out3;
    logic [FracBits:0]   r_fx3, r_fy3;
    always_ff @(posedge i_clk) begin
        r_pr   <= w_r0[0];
        r_pc   <= w_c0[0];
        r_out3 <= w_out;
        r_fx3  <= w_xp.frac;
        r_fy3  <= w_yp.frac;
    end

    // Unscramble banks into neighbor order.
    logic signed [33:0] w_z00, w_z01, w_z10, w_z11;
    assign w_z00 = 34'(signed'(w_rd[{r_pr, r_pc}]));
    assign w_z01 = 34'(signed'(w_rd[{r_pr, ~r_pc}]));
    assign w_z10 = 34'(signed'(w_rd[{~r_pr, r_pc}]));
    assign w_z11 = 34'(signed'(w_rd[{~r_pr, ~r_pc}]));

    // Stage 3: blend along y.
    logic signed [33:0] w_a, w_b;
    logic [FracBits:0]  r_fx4;
    logic               r_out4, r_out5;
    logic signed [33:0] r_near4;

    bti_lerp u_lerp_a (.i_clk(i_clk), .i_a(w_z00), .i_b(w_z01),
                       .i_frac(r_fy3), .o_z(w_a));
    bti_lerp u_lerp_b (.i_clk(i_clk), .i_a(w_z10), .i_b(w_z11),
                       .i_frac(r_fy3), .o_z(w_b));

    always_ff @(posedge i_clk) begin
        r_fx4   <= r_fx3;
        r_out4  <= r_out3;
        r_out5  <= r_out4;
        r_near4 <= w_z00;
    end

    // Stage 4: blend along x; the nearest entry follows beside it.
    logic signed [33:0] w_z;
    logic signed [33:0] r_near5;
    bti_lerp u_lerp_x (.i_clk(i_clk), .i_a(w_a), .i_b(w_b),
                       .i_frac(r_fx4), .o_z(w_z));

    always_ff @(posedge i_clk) begin
        r_near5 <= r_near4;
    end

    // Stage 5: saturate and form the result item.
    t_out_item n_res, r_res;
    always_comb begin
        if (r_wr[Stages-2]) begin
            n_res.z_value = '0;
            n_res.status  = r_wst[Stages-2];
        end else if (r_out5) begin
            n_res.z_value = r_near5[31:0];
            n_res.status  = ST_CLAMPED;
        end else begin
            if (w_z > 34'sh0_7FFF_FFFF) begin
                n_res.z_value = 32'sh7FFF_FFFF;
            end else if (w_z < -34'sh0_8000_0000) begin
                n_res.z_value = 32'sh8000_0000;
            end else begin
                n_res.z_value = w_z[31:0];
            end
            n_res.status = ST_INTERP;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_vld[Stages-1];
    assign o_item  = r_res;

endmodule

### rtl/core/bti_ram.sv
// ----------------------------------------------------------------------------
// bti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bti_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bti_axis.sv
// ----------------------------------------------------------------------------
// bti_axis
// Position arithmetic for one axis over two stages: clamp and offset, then
// multiply by the scale and select cell index and fraction.
// ----------------------------------------------------------------------------
module bti_axis (
    input  logic                     i_clk,
    input  logic signed [31:0]       i_coord,
    input  logic signed [31:0]       i_start,
    input  logic signed [31:0]       i_end,
    input  logic [31:0]              i_scale,
    input  logic [5:0]               i_intv,
    output logic                     o_outside,
    output bti_pkg::t_axis_pos       o_pos_interp,
    output logic [5:0]               o_idx_clamp
);
    import bti_pkg::*;

    logic        n_outside;
    logic [32:0] n_diff;
    logic signed [32:0] w_c;
    logic signed [32:0] w_d;
    logic        r_outside;
    logic [32:0] r_diff;
    logic [31:0] r_scale;
    logic [5:0]  r_intv;
    logic [64:0] w_prod;
    logic [48:0] w_pos;
    logic [32:0] w_cell;

    // Stage A: raise the coordinate to start, then lower it to end, and take
    // the offset from start.
    always_comb begin
        w_c = 33'(i_coord);
        n_outside = 1'b0;
        if (i_coord < i_start) begin
            w_c = 33'(i_start);
            n_outside = 1'b1;
        end
        if (w_c > 33'(i_end)) begin
            w_c = 33'(i_end);
            n_outside = 1'b1;
        end
        w_d = w_c - 33'(i_start);
        n_diff = w_d[32] ? 33'd0 : w_d;
    end

    always_ff @(posedge i_clk) begin
        r_outside <= n_outside;
        r_diff    <= n_diff;
        r_scale   <= i_scale;
        r_intv    <= i_intv;
    end

    // Stage B: scale, then split into cell and fraction.
    always_comb begin
        w_prod = 65'(r_diff) * 65'(r_scale);
        w_pos  = w_prod[FracBits +: 49];
        w_cell = w_pos[FracBits +: 33];
        o_pos_interp.idx  = w_cell[5:0];
        o_pos_interp.frac = {1'b0, w_pos[FracBits-1:0]};
        if (w_cell >= 33'(r_intv)) begin
            o_pos_interp.idx  = r_intv - 6'd1;
            o_pos_interp.frac = {1'b1, {FracBits{1'b0}}};
        end
        o_idx_clamp = (w_cell > 33'(r_intv)) ? r_intv : w_cell[5:0];
    end

    assign o_outside = r_outside;

endmodule

### rtl/core/bti_lerp.sv
// ----------------------------------------------------------------------------
// bti_lerp
// Registered linear blend a + floor((b - a) * f / ONE).
// ----------------------------------------------------------------------------
module bti_lerp (
    input  logic                         i_clk,
    input  logic signed [33:0]           i_a,
    input  logic signed [33:0]           i_b,
    input  logic [bti_pkg::FracBits:0]   i_frac,
    output logic signed [33:0]           o_z
);
    import bti_pkg::*;

    logic signed [34:0] w_diff;
    logic signed [52:0] w_prod;
    logic signed [33:0] r_z;

    // One multiply per blend, registered.
    always_comb begin
        w_diff = 35'(i_b) - 35'(i_a);
        w_prod = 53'(w_diff) * 53'($signed({1'b0, i_frac}));
    end

    always_ff @(posedge i_clk) begin
        r_z <= i_a + 34'(w_prod >>> FracBits);
    end

    assign o_z = r_z;

endmodule
